// ===== src/pfbt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfbt_pkg
// Shared constants and types for the page fill bitmap tracker.
// ----------------------------------------------------------------------------
package pfbt_pkg;

    localparam int unsigned PAGE_SHIFT_DEFAULT = 20;
    localparam int unsigned MAP_WORDS_DEFAULT  = 64;

    // one map word holds 64 pages, msb first
    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned BIT_IDX_W = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_FWD,
        ST_BWD,
        ST_MARK,
        ST_CALC,
        ST_RESULT
    } pfbt_state_t;

    typedef struct packed {
        logic                 any;
        logic [BIT_IDX_W-1:0] first_bit;
        logic [BIT_IDX_W-1:0] last_bit;
    } scan_res_t;

endpackage
`default_nettype wire

// ===== src/pfbt_map_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfbt_map_ram
// Page presence map: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfbt_map_ram #(
    parameter int unsigned DEPTH = pfbt_pkg::MAP_WORDS_DEFAULT,
    parameter int unsigned AW    = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rd_en,
    input  wire logic [AW-1:0]                  rd_addr,
    output logic      [pfbt_pkg::WORD_BITS-1:0] rd_data,
    input  wire logic                           wr_en,
    input  wire logic [AW-1:0]                  wr_addr,
    input  wire logic [pfbt_pkg::WORD_BITS-1:0] wr_data
);
    import pfbt_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/pfbt_word_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfbt_word_scan
// Finds the lowest and highest missing page of one map word inside a bit
// range, and builds the fill mask for that range.
// ----------------------------------------------------------------------------
module pfbt_word_scan (
    input  wire logic [pfbt_pkg::WORD_BITS-1:0] word,
    input  wire logic [pfbt_pkg::BIT_IDX_W-1:0] lo_bit,
    input  wire logic [pfbt_pkg::BIT_IDX_W-1:0] hi_bit,
    output pfbt_pkg::scan_res_t                 res,
    output logic      [pfbt_pkg::WORD_BITS-1:0] fill_mask
);
    import pfbt_pkg::*;

    logic [WORD_BITS-1:0] miss;

    // index of lowest set bit, halving search
    function automatic logic [BIT_IDX_W-1:0] low_one(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] t;
        logic [BIT_IDX_W-1:0] idx;
        t   = v;
        idx = '0;
        for (int k = BIT_IDX_W - 1; k >= 0; k--)
        begin
            if ((t & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0)
            begin
                idx[k] = 1'b1;
                t      = t >> (1 << k);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_IDX_W-1:0] high_one(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] r;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            r[i] = v[WORD_BITS-1-i];
        end
        return BIT_IDX_W'(WORD_BITS - 1) - low_one(r);
    endfunction

    // page offset i sits at word bit 63-i
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            fill_mask[WORD_BITS-1-i] = (BIT_IDX_W'(i) >= lo_bit) && (BIT_IDX_W'(i) <= hi_bit);
            miss[i] = fill_mask[WORD_BITS-1-i] & ~word[WORD_BITS-1-i];
        end
        res.any       = |miss;
        res.first_bit = low_one(miss);
        res.last_bit  = high_one(miss);
    end

endmodule
`default_nettype wire

// ===== src/pfbt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfbt_ctrl
// Request sequencer: clamps the byte range, scans the map forward and
// backward one word a cycle, marks the missing span and forms the result.
// ----------------------------------------------------------------------------
module pfbt_ctrl #(
    parameter int unsigned PAGE_SHIFT = pfbt_pkg::PAGE_SHIFT_DEFAULT,
    parameter int unsigned MAP_WORDS  = pfbt_pkg::MAP_WORDS_DEFAULT,
    parameter int unsigned WA_W       = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_func,
    input  wire logic [31:0]                    in_start,
    input  wire logic [31:0]                    in_end,
    output logic                                busy,
    input  wire logic [31:0]                    file_length,
    output logic                                rd_en,
    output logic      [WA_W-1:0]                rd_addr,
    input  wire logic [pfbt_pkg::WORD_BITS-1:0] rd_data,
    output logic                                wr_en,
    output logic      [WA_W-1:0]                wr_addr,
    output logic      [pfbt_pkg::WORD_BITS-1:0] wr_data,
    output logic                                res_valid,
    input  wire logic                           res_take,
    output logic                                res_fetch,
    output logic      [11:0]                    res_first,
    output logic      [11:0]                    res_last,
    output logic      [31:0]                    res_offset,
    output logic      [31:0]                    res_length
);
    import pfbt_pkg::*;

    localparam int unsigned PG_W      = WA_W + BIT_IDX_W;
    localparam int unsigned MAP_PAGES = MAP_WORDS * WORD_BITS;
    // wide enough for the byte span and for the full file_length
    localparam int unsigned OFF_RAW   = PG_W + PAGE_SHIFT + 1;
    localparam int unsigned OFF_W     = (OFF_RAW > 33) ? OFF_RAW : 33;

    pfbt_state_t          state_reg, state_next;
    logic [WA_W-1:0]      ptr_reg, ptr_next;
    logic [WA_W-1:0]      chk_reg, chk_next;
    logic                 dv_reg, dv_next;
    logic                 issued_reg, issued_next;
    logic                 clr_res_reg, clr_res_next;
    logic                 found_reg, found_next;
    logic [31:0]          sb_reg, sb_next;
    logic [31:0]          e_reg, e_next;
    logic [PG_W-1:0]      lo_pg_reg, lo_pg_next;
    logic [PG_W-1:0]      hi_pg_reg, hi_pg_next;
    logic [PG_W-1:0]      first_reg, first_next;
    logic [PG_W-1:0]      last_reg, last_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [OFF_W-1:0]     endb_reg, endb_next;

    logic [WA_W-1:0]      lo_w, hi_w;
    logic [BIT_IDX_W-1:0] lo_bit, hi_bit;
    logic [PG_W-1:0]      p0, p1;
    scan_res_t            scan;
    logic [WORD_BITS-1:0] fill_mask;
    logic [OFF_W-1:0]     span, room, len;
    logic [31:0]          first32, last32;

    function automatic logic [PG_W-1:0] to_page(input logic [31:0] b);
        logic [31:0] q;
        q = b >> PAGE_SHIFT;
        return (q > 32'(MAP_PAGES - 1)) ? PG_W'(MAP_PAGES - 1) : PG_W'(q);
    endfunction

    assign lo_w   = lo_pg_reg[PG_W-1:BIT_IDX_W];
    assign hi_w   = hi_pg_reg[PG_W-1:BIT_IDX_W];
    assign lo_bit = (chk_reg == lo_w) ? lo_pg_reg[BIT_IDX_W-1:0] : '0;
    assign hi_bit = (chk_reg == hi_w) ? hi_pg_reg[BIT_IDX_W-1:0] : '1;
    assign p0     = to_page(sb_reg);
    assign p1     = to_page(e_reg);

    pfbt_word_scan u_scan (
        .word      (rd_data),
        .lo_bit    (lo_bit),
        .hi_bit    (hi_bit),
        .res       (scan),
        .fill_mask (fill_mask)
    );

    // offset never exceeds file_length, so room does not wrap
    assign span    = endb_reg - off_reg;
    assign room    = OFF_W'(file_length) - off_reg;
    assign len     = (span < room) ? span : room;
    assign first32 = 32'(first_reg);
    assign last32  = 32'(last_reg);

    assign busy       = (state_reg != ST_IDLE);
    assign res_valid  = (state_reg == ST_RESULT);
    assign res_fetch  = found_reg;
    assign res_first  = found_reg ? first32[11:0] : '0;
    assign res_last   = found_reg ? last32[11:0] : '0;
    assign res_offset = found_reg ? 32'(off_reg) : '0;
    assign res_length = found_reg ? 32'(len) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            ptr_reg     <= '0;
            dv_reg      <= 1'b0;
            issued_reg  <= 1'b0;
            clr_res_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            dv_reg      <= dv_next;
            issued_reg  <= issued_next;
            clr_res_reg <= clr_res_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg   <= chk_next;
        sb_reg    <= sb_next;
        e_reg     <= e_next;
        lo_pg_reg <= lo_pg_next;
        hi_pg_reg <= hi_pg_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        off_reg   <= off_next;
        endb_reg  <= endb_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        chk_next     = chk_reg;
        dv_next      = dv_reg;
        issued_next  = issued_reg;
        clr_res_next = clr_res_reg;
        found_next   = found_reg;
        sb_next      = sb_reg;
        e_next       = e_reg;
        lo_pg_next   = lo_pg_reg;
        hi_pg_next   = hi_pg_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        off_next     = off_reg;
        endb_next    = endb_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;
        wr_en        = 1'b0;
        wr_addr      = chk_reg;
        wr_data      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                if (ptr_reg == WA_W'(MAP_WORDS - 1))
                begin
                    ptr_next     = '0;
                    found_next   = 1'b0;
                    clr_res_next = 1'b0;
                    state_next   = clr_res_reg ? ST_CALC : ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + WA_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_func)
                    begin
                        clr_res_next = 1'b1;
                        ptr_next     = '0;
                        state_next   = ST_CLEAR;
                    end
                    else
                    begin
                        sb_next    = in_start;
                        e_next     = (in_end < file_length) ? in_end : file_length;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                found_next = 1'b0;
                // start at or past the clamped end: nothing to look at
                if (!(sb_reg < e_reg))
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    lo_pg_next  = p0;
                    hi_pg_next  = p1;
                    ptr_next    = p0[PG_W-1:BIT_IDX_W];
                    dv_next     = 1'b0;
                    issued_next = 1'b0;
                    state_next  = ST_FWD;
                end
            end
            ST_FWD:
            begin
                rd_en    = !issued_reg;
                dv_next  = rd_en;
                chk_next = ptr_reg;
                if (rd_en)
                begin
                    issued_next = (ptr_reg == hi_w);
                    if (ptr_reg != hi_w)
                    begin
                        ptr_next = ptr_reg + WA_W'(1);
                    end
                end
                if (dv_reg)
                begin
                    if (scan.any)
                    begin
                        first_next  = {chk_reg, scan.first_bit};
                        ptr_next    = hi_w;
                        issued_next = 1'b0;
                        dv_next     = 1'b0;
                        state_next  = ST_BWD;
                    end
                    else if (chk_reg == hi_w)
                    begin
                        dv_next    = 1'b0;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_BWD:
            begin
                rd_en    = !issued_reg;
                dv_next  = rd_en;
                chk_next = ptr_reg;
                if (rd_en)
                begin
                    issued_next = (ptr_reg == lo_w);
                    if (ptr_reg != lo_w)
                    begin
                        ptr_next = ptr_reg - WA_W'(1);
                    end
                end
                if (dv_reg)
                begin
                    if (scan.any)
                    begin
                        last_next   = {chk_reg, scan.last_bit};
                        found_next  = 1'b1;
                        lo_pg_next  = first_reg;
                        hi_pg_next  = {chk_reg, scan.last_bit};
                        ptr_next    = first_reg[PG_W-1:BIT_IDX_W];
                        issued_next = 1'b0;
                        dv_next     = 1'b0;
                        state_next  = ST_MARK;
                    end
                    else if (chk_reg == lo_w)
                    begin
                        dv_next    = 1'b0;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_MARK:
            begin
                // read runs one word ahead of the write back
                rd_en    = !issued_reg;
                dv_next  = rd_en;
                chk_next = ptr_reg;
                if (rd_en)
                begin
                    issued_next = (ptr_reg == hi_w);
                    if (ptr_reg != hi_w)
                    begin
                        ptr_next = ptr_reg + WA_W'(1);
                    end
                end
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = chk_reg;
                    wr_data = rd_data | fill_mask;
                    if (chk_reg == hi_w)
                    begin
                        dv_next    = 1'b0;
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                off_next   = OFF_W'(first_reg) << PAGE_SHIFT;
                endb_next  = (OFF_W'(last_reg) + OFF_W'(1)) << PAGE_SHIFT;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/page_fill_bitmap_tracker_top.sv =====
// ----------------------------------------------------------------------------
// page_fill_bitmap_tracker_top
// Page presence bitmap for a bound file. A fill beat (func 0) clamps its byte
// range to file_length, finds the first and last missing page, marks the span
// between them present and returns the fetch offset and length; a clear beat
// (func 1) empties the map. One beat is handled at a time, and every beat
// gives one result beat. The map lives in a MAP_WORDS x 64 memory with one
// read and one write port, and the read port walks one word per cycle: a fill
// reads the words forward to the first missing page, backward to the last one
// and across the marked span, and those words add up to at most MAP_WORDS + 2.
// A clear writes every map word to zero. A result that finds the output
// register still full waits in the sequencer until it drains. After reset the
// map is swept to zero with in_stall high. file_length is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while no beat is in
// flight, and the block itself does not enforce this. The result sits in an
// output register, so a new beat is taken while the last result is still
// stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module page_fill_bitmap_tracker_top #(
    parameter int unsigned PAGE_SHIFT = pfbt_pkg::PAGE_SHIFT_DEFAULT,
    parameter int unsigned MAP_WORDS  = pfbt_pkg::MAP_WORDS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [31:0] start_byte,
    input  wire logic [31:0] end_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             must_fetch,
    output logic      [11:0] first_missing_page,
    output logic      [11:0] last_missing_page,
    output logic      [31:0] fetch_offset,
    output logic      [31:0] fetch_length,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);
    import pfbt_pkg::*;

    localparam int unsigned WA_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [31:0]          file_length_reg;
    logic                 out_valid_reg;
    logic                 must_fetch_reg;
    logic [11:0]          first_reg;
    logic [11:0]          last_reg;
    logic [31:0]          offset_reg;
    logic [31:0]          length_reg;

    logic                 busy;
    logic                 rd_en;
    logic [WA_W-1:0]      rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [WA_W-1:0]      wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 res_valid;
    logic                 res_take;
    logic                 res_fetch;
    logic [11:0]          res_first;
    logic [11:0]          res_last;
    logic [31:0]          res_offset;
    logic [31:0]          res_length;

    pfbt_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (WA_W)
    ) u_map (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pfbt_ctrl #(
        .PAGE_SHIFT (PAGE_SHIFT),
        .MAP_WORDS  (MAP_WORDS),
        .WA_W       (WA_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_func     (func),
        .in_start    (start_byte),
        .in_end      (end_byte),
        .busy        (busy),
        .file_length (file_length_reg),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_fetch   (res_fetch),
        .res_first   (res_first),
        .res_last    (res_last),
        .res_offset  (res_offset),
        .res_length  (res_length)
    );

    // output slot is free when empty or being drained this cycle
    assign res_take = !out_valid_reg || !out_stall;
    assign in_stall = busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                file_length_reg <= cfg_wr_data;
            end
            if (res_take)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            must_fetch_reg <= res_fetch;
            first_reg      <= res_first;
            last_reg       <= res_last;
            offset_reg     <= res_offset;
            length_reg     <= res_length;
        end
    end

    assign out_valid          = out_valid_reg;
    assign must_fetch         = must_fetch_reg;
    assign first_missing_page = first_reg;
    assign last_missing_page  = last_reg;
    assign fetch_offset       = offset_reg;
    assign fetch_length       = length_reg;

endmodule
`default_nettype wire

// ===== src/pfbt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfbt_checker
// Port-level checks for the page fill bitmap tracker, bound to the top.
// ----------------------------------------------------------------------------
module pfbt_checker #(
    parameter int unsigned PAGE_SHIFT = pfbt_pkg::PAGE_SHIFT_DEFAULT
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        must_fetch,
    input wire logic [11:0] first_missing_page,
    input wire logic [11:0] last_missing_page,
    input wire logic [31:0] fetch_offset,
    input wire logic [31:0] fetch_length
);

    // held result beat keeps its fetch flag, offset and length
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(must_fetch)
            && $stable(fetch_offset) && $stable(fetch_length))
        else $error("stalled result beat changed");

    // a beat with nothing to fetch carries all zero fields
    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !must_fetch |-> first_missing_page == 12'd0
            && last_missing_page == 12'd0 && fetch_offset == 32'd0
            && fetch_length == 32'd0)
        else $error("non-fetch result has nonzero fields");

    // fetch offset is page aligned
    a_offset_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && must_fetch |->
            (fetch_offset & ((32'd1 << PAGE_SHIFT) - 32'd1)) == 32'd0)
        else $error("fetch offset not page aligned");

    // one request at a time: an accepted beat stalls the next
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    // map sweep after reset holds off input
    a_reset_sweep: assert property (@(posedge clk)
        !rst_n |=> in_stall)
        else $error("input not stalled right after reset");

endmodule

bind page_fill_bitmap_tracker_top pfbt_checker #(
    .PAGE_SHIFT (PAGE_SHIFT)
) u_pfbt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .must_fetch         (must_fetch),
    .first_missing_page (first_missing_page),
    .last_missing_page  (last_missing_page),
    .fetch_offset       (fetch_offset),
    .fetch_length       (fetch_length)
);
`default_nettype wire
